@@ rtl/core/gaussian_potential_cost_assert.svh @@
// Assertion macros for the cost block.
`ifndef GAUSSIAN_POTENTIAL_COST_ASSERT_SVH
`define GAUSSIAN_POTENTIAL_COST_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked check, off during reset
`define GPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, always on
`define GPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/gpc_pkg.sv @@
package gpc_pkg;

	localparam int DIMS = 6;
	localparam int COORD_W = 16;

	localparam logic [27:0] LN2_Q24 = 28'd11629080;
	// 17 * ln2: any t at or above this gives exp(-t) of zero
	localparam logic [34:0] EXP_LIMIT = 35'(17 * 11629080);
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [63:0] TWO32 = 64'h1_0000_0000;

	// floor(2^32 / n) for n = 1..8, indexed by n - 1
	localparam logic [32:0] RECIP_TBL [8] = '{
		33'(TWO32 / 64'd1), 33'(TWO32 / 64'd2), 33'(TWO32 / 64'd3), 33'(TWO32 / 64'd4),
		33'(TWO32 / 64'd5), 33'(TWO32 / 64'd6), 33'(TWO32 / 64'd7), 33'(TWO32 / 64'd8)
	};

	localparam logic [1:0] REG_PEAK_WEIGHT = 2'd0;
	localparam logic [1:0] REG_INV_SPREAD = 2'd1;
	localparam logic [1:0] REG_ACTIVE_CENTERS = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef logic [DIMS-1:0][COORD_W-1:0] center_t;

	typedef struct packed {
		logic [15:0] peak_weight;
		logic [15:0] inv_spread;
	} eng_cfg_t;

	typedef struct packed {
		logic        done;
		logic [32:0] term;
	} eng_res_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_SQ,
		E_SCL,
		E_DIV0,
		E_DIVS,
		E_HA,
		E_HB,
		E_HC,
		E_EXP,
		E_DONE
	} eng_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_ISSUE,
		T_WAIT,
		T_FINISH
	} top_state_t;

endpackage

@@ rtl/core/gaussian_potential_cost.sv @@
// Channel    Handshake               Payload
// request    start && !busy          req_type, center_slot, coord_0..coord_5
// result     cost_valid (1 cycle)    cost_value, saturated
// config     cfg_we                  cfg_index, cfg_wdata
//
// A load transaction writes the addressed slot; busy stays low.
// An evaluate transaction holds busy while it works through the first
// N = min(active_centers, MAX_CENTERS) centers; the strobe rises as busy falls.
// Each center runs issue, the six squares, scale, range check, the ln2 reduction,
// eight Horner steps of three passes, weight and handoff.
// A center whose term underflows skips reduction and Horner.
// Reset clears control and presets configuration; the center table is not reset.
// The result is shown for one cycle; the receiver cannot stall it.
module gaussian_potential_cost #(
	parameter int MAX_CENTERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [3:0]  center_slot,
	input  logic [15:0] coord_0,
	input  logic [15:0] coord_1,
	input  logic [15:0] coord_2,
	input  logic [15:0] coord_3,
	input  logic [15:0] coord_4,
	input  logic [15:0] coord_5,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output logic        cost_valid,
	output logic [19:0] cost_value,
	output logic        saturated
);
	import gpc_pkg::*;

	`include "gaussian_potential_cost_assert.svh"

	localparam int CNT_W = $clog2(MAX_CENTERS + 1);
	localparam int TOT_W = 33 + CNT_W;
	localparam int RND_W = TOT_W + 2;

	top_state_t state_q, state_d;
	logic [CNT_W-1:0] remain_q, remain_d;
	logic [TOT_W-1:0] total_q;

	logic [15:0] peak_weight_q;
	logic [15:0] inv_spread_q;
	logic [4:0]  active_centers_q;

	center_t point_q;
	center_t in_point;
	center_t chain [MAX_CENTERS];

	logic accept, do_load, do_eval, do_shift, eng_start;
	logic [CNT_W-1:0] count_lim;
	eng_cfg_t eng_cfg;
	eng_res_t eng_res;

	logic [RND_W-1:0] rnd;
	logic [RND_W-17:0] cost_full;
	logic cost_sat;
	logic [19:0] cost_val;

	assign in_point = {coord_5, coord_4, coord_3, coord_2, coord_1, coord_0};
	assign accept = start && !busy;
	assign do_load = accept && (req_type == REQ_LOAD);
	assign do_eval = accept && (req_type == REQ_EVAL);
	assign count_lim = (32'(active_centers_q) > MAX_CENTERS) ?
		CNT_W'(MAX_CENTERS) : CNT_W'(active_centers_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_weight_q <= 16'd36864;
			inv_spread_q <= 16'd21845;
			active_centers_q <= 5'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEAK_WEIGHT: peak_weight_q <= cfg_wdata;
				REG_INV_SPREAD: inv_spread_q <= cfg_wdata;
				REG_ACTIVE_CENTERS: active_centers_q <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	for (genvar j = 0; j < MAX_CENTERS; j++) begin : g_cell
		center_t nxt;
		if (j == MAX_CENTERS - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = chain[j+1];
		end
		gpc_cell u_cell (
			.clk       (clk),
			.load_en   (do_load && (32'(center_slot) == j)),
			.capture   (do_eval),
			.shift     (do_shift),
			.load_data (in_point),
			.shift_in  (nxt),
			.shift_out (chain[j])
		);
	end

	assign eng_cfg.peak_weight = peak_weight_q;
	assign eng_cfg.inv_spread = inv_spread_q;

	gpc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.point  (point_q),
		.center (chain[0]),
		.cfg    (eng_cfg),
		.res    (eng_res)
	);

	always_comb begin
		state_d = state_q;
		remain_d = remain_q;
		eng_start = 1'b0;
		do_shift = 1'b0;
		case (state_q)
			T_IDLE: begin
				if (do_eval) begin
					remain_d = count_lim;
					state_d = (count_lim == '0) ? T_FINISH : T_ISSUE;
				end
			end
			T_ISSUE: begin
				eng_start = 1'b1;
				state_d = T_WAIT;
			end
			T_WAIT: begin
				if (eng_res.done) begin
					do_shift = 1'b1;
					remain_d = remain_q - CNT_W'(1);
					state_d = (remain_q == CNT_W'(1)) ? T_FINISH : T_ISSUE;
				end
			end
			T_FINISH: state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			remain_q <= '0;
			cost_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			remain_q <= remain_d;
			cost_valid <= (state_q == T_FINISH);
		end
	end

	assign busy = (state_q != T_IDLE);

	assign rnd = RND_W'(total_q) + RND_W'(32768);
	assign cost_full = rnd[RND_W-1:16];
	assign cost_sat = |cost_full[RND_W-17:20];
	assign cost_val = cost_sat ? 20'hFFFFF : cost_full[19:0];

	always_ff @(posedge clk) begin
		if (do_eval) begin
			point_q <= in_point;
			total_q <= TOT_W'(1) << 28;
		end else if ((state_q == T_WAIT) && eng_res.done) begin
			total_q <= total_q + TOT_W'(eng_res.term);
		end
		if (state_q == T_FINISH) begin
			cost_value <= cost_val;
			saturated <= cost_sat;
		end
	end

	`GPC_ASSERT(a_strobe_single, clk, arst_n, cost_valid |=> !cost_valid, "result strobe held")
	`GPC_ASSERT(a_sat_full, clk, arst_n, (cost_valid && saturated) |-> (cost_value == 20'hFFFFF), "saturated result not full scale")
	`GPC_ASSERT(a_done_in_wait, clk, arst_n, eng_res.done |-> (state_q == T_WAIT), "engine result outside wait")
	`GPC_ASSERT(a_eval_busy, clk, arst_n, do_eval |=> busy, "evaluate transaction did not raise busy")

endmodule

@@ rtl/core/gpc_cell.sv @@
module gpc_cell (
	input  logic             clk,
	input  logic             load_en,
	input  logic             capture,
	input  logic             shift,
	input  gpc_pkg::center_t load_data,
	input  gpc_pkg::center_t shift_in,
	output gpc_pkg::center_t shift_out
);
	import gpc_pkg::*;

	center_t center_q;
	center_t stage_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			center_q <= load_data;
		end
	end

	// stage copies the stored center, then walks toward the head
	always_ff @(posedge clk) begin
		if (capture) begin
			stage_q <= center_q;
		end else if (shift) begin
			stage_q <= shift_in;
		end
	end

	assign shift_out = stage_q;

endmodule

@@ rtl/core/gpc_engine.sv @@
module gpc_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gpc_pkg::center_t  point,
	input  gpc_pkg::center_t  center,
	input  gpc_pkg::eng_cfg_t cfg,
	output gpc_pkg::eng_res_t res
);
	import gpc_pkg::*;

	eng_state_t st_q, st_d;
	logic [2:0] cnt_q, cnt_d;
	logic [2:0] nm1_q, nm1_d;

	logic [34:0] normsq_q;
	logic [27:0] rem_q;
	logic [4:0]  k_q;
	logic [32:0] q_q;
	logic [31:0] x_q;
	logic        zero_q;
	logic [67:0] prod_q;

	logic [34:0] mul_a;
	logic [32:0] mul_b;
	logic [2:0]  dim_sel;
	logic [15:0] pa, pb, absdiff;
	logic [34:0] t_val;
	logic [27:0] ln2_sh;
	logic [31:0] r_val;
	logic [31:0] q0;
	logic [3:0]  n_val;
	logic [35:0] qn;
	logic [35:0] div_rem;
	logic [32:0] qd;
	logic [32:0] q_sh;
	logic [32:0] e_sum;
	logic [16:0] e_val;

	assign dim_sel = (cnt_q < 3'(DIMS)) ? cnt_q : 3'd0;
	assign pa = point[dim_sel];
	assign pb = center[dim_sel];
	assign absdiff = (pa >= pb) ? (pa - pb) : (pb - pa);

	assign t_val = prod_q[50:16];
	assign ln2_sh = LN2_Q24 << cnt_q;
	assign r_val = {rem_q[23:0], 8'd0};

	assign n_val = {1'b0, nm1_q} + 4'd1;
	assign q0 = prod_q[63:32];
	assign qn = 36'(q0) * 36'(n_val);
	assign div_rem = 36'(x_q) - qn;
	assign qd = (div_rem >= 36'(n_val)) ? (33'(q0) + 33'd1) : 33'(q0);

	assign q_sh = q_q >> k_q;
	assign e_sum = q_sh + 33'd32768;
	assign e_val = zero_q ? 17'd0 : e_sum[32:16];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			E_SQ: begin
				mul_a = 35'(absdiff);
				mul_b = 33'(absdiff);
			end
			E_SCL: begin
				mul_a = normsq_q;
				mul_b = 33'(cfg.inv_spread);
			end
			E_HA: begin
				mul_a = 35'(r_val);
				mul_b = q_q;
			end
			E_HB: begin
				mul_a = 35'(prod_q[63:32]);
				mul_b = RECIP_TBL[nm1_q];
			end
			E_EXP: begin
				mul_a = 35'(cfg.peak_weight);
				mul_b = 33'(e_val);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		nm1_d = nm1_q;
		case (st_q)
			E_IDLE: begin
				if (start) begin
					st_d = E_SQ;
					cnt_d = '0;
				end
			end
			E_SQ: begin
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'(DIMS)) begin
					st_d = E_SCL;
				end
			end
			E_SCL: st_d = E_DIV0;
			E_DIV0: begin
				cnt_d = 3'd4;
				st_d = (t_val >= EXP_LIMIT) ? E_EXP : E_DIVS;
			end
			E_DIVS: begin
				cnt_d = cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					st_d = E_HA;
					nm1_d = 3'd7;
				end
			end
			E_HA: st_d = E_HB;
			E_HB: st_d = E_HC;
			E_HC: begin
				nm1_d = nm1_q - 3'd1;
				st_d = (nm1_q == 3'd0) ? E_EXP : E_HA;
			end
			E_EXP: st_d = E_DONE;
			E_DONE: st_d = E_IDLE;
			default: st_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			cnt_q <= '0;
			nm1_q <= '0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			nm1_q <= nm1_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 68'(mul_a) * 68'(mul_b);
		case (st_q)
			E_IDLE: begin
				normsq_q <= '0;
			end
			E_SQ: begin
				if (cnt_q != 3'd0) begin
					normsq_q <= normsq_q + 35'(prod_q[31:0]);
				end
			end
			E_DIV0: begin
				zero_q <= (t_val >= EXP_LIMIT);
				rem_q <= t_val[27:0];
				k_q <= '0;
			end
			E_DIVS: begin
				if (rem_q >= ln2_sh) begin
					rem_q <= rem_q - ln2_sh;
					k_q[cnt_q] <= 1'b1;
				end
				q_q <= ONE_Q32;
			end
			E_HB: begin
				x_q <= prod_q[63:32];
			end
			E_HC: begin
				q_q <= ONE_Q32 - qd;
			end
			default: begin
			end
		endcase
	end

	assign res.done = (st_q == E_DONE);
	assign res.term = prod_q[32:0];

endmodule

@@ dv/gaussian_potential_cost_test.sv @@
module gaussian_potential_cost_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gpc_pkg::*;

	localparam int CENTERS = 16;
	localparam int NUM_DIMS = 6;
	localparam logic [63:0] LN2_UNITS = 64'd11629080;
	localparam logic [63:0] UNITY_Q32 = 64'h1_0000_0000;
	localparam logic [19:0] COST_FULL = 20'hFFFFF;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 60;
	localparam int STEADY_PHASE = 5;
	localparam longint CYCLE_LIMIT = 4_000_000;

	typedef logic [NUM_DIMS-1:0][15:0] point_t;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  slot;
		point_t      coords;
	} request_t;

	typedef struct packed {
		logic [19:0] cost;
		logic        sat;
	} cost_t;

	class cost_scoreboard;
		point_t      centers [CENTERS];
		logic [15:0] peak_weight;
		logic [15:0] inv_spread;
		logic [4:0]  active_centers;
		cost_t       expected_costs [$];
		int          errors;

		function new();
			peak_weight = 16'd36864;
			inv_spread = 16'd21845;
			active_centers = 5'd10;
			errors = 0;
			foreach (centers[i])
				centers[i] = '0;
		endfunction

		function void write_register(logic [1:0] index, logic [15:0] data);
			case (index)
				REG_PEAK_WEIGHT: peak_weight = data;
				REG_INV_SPREAD: inv_spread = data;
				REG_ACTIVE_CENTERS: active_centers = data[4:0];
				default: ;
			endcase
		endfunction

		function int live_centers();
			return (active_centers > CENTERS) ? CENTERS : int'(active_centers);
		endfunction

		// exp(-t), t in units 2^-24, result in units 2^-16
		static function logic [16:0] neg_exp(logic [63:0] t);
			logic [63:0] k;
			logic [63:0] r;
			logic [63:0] q;
			k = t / LN2_UNITS;
			if (k >= 64'd17)
				return '0;
			r = (t - k * LN2_UNITS) << 8;
			q = UNITY_Q32;
			for (int n = 8; n >= 1; n--)
				q = UNITY_Q32 - (((r * q) >> 32) / 64'(n));
			return 17'(((q >> k) + 64'd32768) >> 16);
		endfunction

		function cost_t predict_cost(point_t pt);
			logic [63:0] total;
			logic [63:0] normsq;
			logic [63:0] d;
			logic [63:0] t;
			cost_t res;
			total = 64'd1 << 28;
			for (int j = 0; j < live_centers(); j++) begin
				normsq = '0;
				for (int i = 0; i < NUM_DIMS; i++) begin
					if (pt[i] >= centers[j][i])
						d = 64'(pt[i]) - 64'(centers[j][i]);
					else
						d = 64'(centers[j][i]) - 64'(pt[i]);
					normsq += d * d;
				end
				t = (normsq * 64'(inv_spread)) >> 16;
				total += 64'(peak_weight) * 64'(neg_exp(t));
			end
			total = (total + 64'd32768) >> 16;
			if (total > 64'(COST_FULL)) begin
				res.cost = COST_FULL;
				res.sat = 1'b1;
			end else begin
				res.cost = total[19:0];
				res.sat = 1'b0;
			end
			return res;
		endfunction

		function void note_request(request_t item);
			if (item.req_type == REQ_LOAD)
				centers[item.slot] = item.coords;
			else
				expected_costs.push_back(predict_cost(item.coords));
		endfunction

		function void check_result(logic [19:0] cost, logic sat);
			cost_t want;
			if (expected_costs.size() == 0) begin
				errors++;
				$display("%0t: cost result %h sat %b with no evaluate transaction pending",
					$time, cost, sat);
				return;
			end
			want = expected_costs.pop_front();
			if (cost !== want.cost) begin
				errors++;
				$display("%0t: cost_value expected %h actual %h", $time, want.cost, cost);
			end
			if (sat !== want.sat) begin
				errors++;
				$display("%0t: saturated expected %b actual %b", $time, want.sat, sat);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [3:0]  center_slot;
	logic [15:0] coord_0;
	logic [15:0] coord_1;
	logic [15:0] coord_2;
	logic [15:0] coord_3;
	logic [15:0] coord_4;
	logic [15:0] coord_5;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        cost_valid;
	logic [19:0] cost_value;
	logic        saturated;

	bit steady = 1'b0;
	cost_scoreboard sb = new();

	gaussian_potential_cost dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.center_slot(center_slot),
		.coord_0(coord_0),
		.coord_1(coord_1),
		.coord_2(coord_2),
		.coord_3(coord_3),
		.coord_4(coord_4),
		.coord_5(coord_5),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cost_valid(cost_valid),
		.cost_value(cost_value),
		.saturated(saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && cost_valid === 1'b1)
			sb.check_result(cost_value, saturated);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("gaussian_potential_cost regression: fail");
		$finish;
	end

	function automatic request_t load_item(logic [3:0] slot, point_t coords);
		request_t item;
		item.req_type = REQ_LOAD;
		item.slot = slot;
		item.coords = coords;
		return item;
	endfunction

	function automatic request_t eval_item(point_t coords);
		request_t item;
		item.req_type = REQ_EVAL;
		item.slot = 4'($urandom);
		item.coords = coords;
		return item;
	endfunction

	function automatic point_t random_point();
		point_t p;
		for (int i = 0; i < NUM_DIMS; i++)
			p[i] = 16'($urandom);
		return p;
	endfunction

	function automatic point_t near_center(int j, int spread);
		point_t p;
		int v;
		for (int i = 0; i < NUM_DIMS; i++) begin
			v = int'(sb.centers[j][i]) + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			p[i] = 16'(v);
		end
		return p;
	endfunction

	task automatic send_request(request_t item);
		@(negedge clk);
		start <= 1'b1;
		req_type <= item.req_type;
		center_slot <= item.slot;
		coord_0 <= item.coords[0];
		coord_1 <= item.coords[1];
		coord_2 <= item.coords[2];
		coord_3 <= item.coords[3];
		coord_4 <= item.coords[4];
		coord_5 <= item.coords[5];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(item);
	endtask

	task automatic idle_gap();
		int n;
		n = 0;
		if (steady)
			return;
		while ($urandom_range(0, 99) < 19)
			n++;
		// occasional long pause so the next start lands anywhere in a busy period
		if ($urandom_range(0, 99) < 3)
			n += $urandom_range(1, 700);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_costs.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_register(index, data);
	endtask

	task automatic apply_settings(logic [15:0] peak, logic [15:0] inv, logic [15:0] count_word);
		write_register(REG_PEAK_WEIGHT, peak);
		write_register(REG_NONE, 16'($urandom));
		write_register(REG_INV_SPREAD, inv);
		write_register(REG_ACTIVE_CENTERS, count_word);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_settings();
		logic [15:0] peak;
		logic [15:0] inv;
		int count;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// all centers count, each near full weight: the sum can pass full scale
			peak = 16'($urandom_range(65280, 65535));
			inv = 16'($urandom_range(0, 3));
			count = $urandom_range(16, 31);
		end else begin
			case ($urandom_range(0, 4))
				0: peak = 16'h0000;
				1: peak = 16'hFFFF;
				2: peak = 16'd36864;
				default: peak = 16'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0: inv = 16'h0000;
				1: inv = 16'hFFFF;
				2: inv = 16'd21845;
				3: inv = 16'($urandom_range(0, 4095));
				default: inv = 16'($urandom);
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 5)
				count = 0;
			else if (pick < 60)
				count = $urandom_range(1, 4);
			else if (pick < 75)
				count = $urandom_range(5, 15);
			else if (pick < 95)
				count = 16;
			else
				count = $urandom_range(17, 31);
		end
		apply_settings(peak, inv, {11'($urandom), 5'(count)});
	endtask

	task automatic random_item();
		int roll;
		int live;
		int spread;
		roll = $urandom_range(0, 99);
		live = sb.live_centers();
		case ($urandom_range(0, 4))
			0: spread = 0;
			1: spread = 256;
			2: spread = 2048;
			3: spread = 8192;
			default: spread = 32768;
		endcase
		idle_gap();
		if (roll < 30) begin
			if ($urandom_range(0, 99) < 70)
				send_request(load_item(4'($urandom), random_point()));
			else
				send_request(load_item(4'($urandom),
					near_center($urandom_range(0, CENTERS - 1), spread)));
		end else if (roll < 90) begin
			send_request(eval_item(near_center($urandom_range(0, (live > 0) ? live - 1 :
				CENTERS - 1), spread)));
		end else begin
			send_request(eval_item(random_point()));
		end
	endtask

	initial begin
		point_t p;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_LOAD;
		center_slot = '0;
		coord_0 = '0;
		coord_1 = '0;
		coord_2 = '0;
		coord_3 = '0;
		coord_4 = '0;
		coord_5 = '0;
		cfg_we = 1'b0;
		cfg_index = REG_PEAK_WEIGHT;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the whole table before any evaluate
		send_request(load_item(4'd0, '0));
		for (int s = 1; s < CENTERS - 1; s++)
			send_request(load_item(4'(s), random_point()));
		send_request(load_item(4'd15, '1));

		send_request(eval_item('0));
		send_request(eval_item('1));
		send_request(eval_item(near_center(3, 1024)));

		// no centers: upper bits of the count word must be dropped
		drain();
		apply_settings(16'd36864, 16'd21845, 16'hFFE0);
		send_request(eval_item(near_center(0, 512)));

		// count clamps to the table size, sum saturates
		drain();
		apply_settings(16'hFFFF, 16'h0000, 16'h001F);
		send_request(eval_item(random_point()));

		drain();
		apply_settings(16'h0000, 16'hFFFF, 16'h0011);
		send_request(eval_item(near_center(15, 256)));

		drain();
		apply_settings(16'h1000, 16'hFFFF, 16'h0010);
		send_request(eval_item('1));
		p = random_point();
		send_request(load_item(4'd2, p));
		send_request(eval_item(p));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			random_settings();
			steady = (ph == STEADY_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.expected_costs.size() != 0)
			$display("%0t: %0d expected cost results never arrived", $time,
				sb.expected_costs.size());
		if (sb.errors == 0 && sb.expected_costs.size() == 0)
			$display("gaussian_potential_cost regression: pass");
		else
			$display("gaussian_potential_cost regression: fail");
		$finish;
	end

endmodule
